// ===== sv/trsp_pkg.sv =====
// Shared types, codes and helpers for the tar record stream parser.
`default_nettype none

package trsp_pkg;

    localparam int unsigned RECORD_BYTES = 512;
    localparam int unsigned OFS_W        = $clog2(RECORD_BYTES);
    localparam int unsigned SIZE_W       = 36;
    localparam int unsigned CSUM_W       = 24;
    localparam int unsigned SUM_W        = 17;

    localparam logic [OFS_W-1:0] OFS_LAST       = OFS_W'(RECORD_BYTES - 1);
    localparam logic [OFS_W-1:0] OFS_NAME_END   = OFS_W'(100);
    localparam logic [OFS_W-1:0] OFS_SIZE_FIRST = OFS_W'(124);
    localparam logic [OFS_W-1:0] OFS_SIZE_LAST  = OFS_W'(135);
    localparam logic [OFS_W-1:0] OFS_CSUM_FIRST = OFS_W'(148);
    localparam logic [OFS_W-1:0] OFS_CSUM_LAST  = OFS_W'(155);
    localparam logic [OFS_W-1:0] OFS_LINK       = OFS_W'(156);

    localparam logic [7:0] CHAR_SPACE    = 8'h20;
    localparam logic [7:0] CHAR_SLASH    = 8'h2F;
    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] CHAR_SEVEN    = 8'h37;
    localparam logic [7:0] CHAR_HARDLINK = 8'h31;

    typedef enum logic [2:0] {
        MODE_HEADER  = 3'd0,
        MODE_PAYLOAD = 3'd1,
        MODE_PADDING = 3'd2,
        MODE_END     = 3'd3,
        MODE_ERROR   = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        KIND_HEADER      = 3'd0,
        KIND_PAYLOAD     = 3'd1,
        KIND_PADDING     = 3'd2,
        KIND_END_RECORD  = 3'd3,
        KIND_AFTER_END   = 3'd4,
        KIND_AFTER_ERROR = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_FILE      = 3'd1,
        EV_DIRECTORY = 3'd2,
        EV_HARDLINK  = 3'd3,
        EV_END       = 3'd4,
        EV_CSUM_ERR  = 3'd5
    } event_t;

    typedef enum logic [1:0] {
        PH_SKIP    = 2'd0,
        PH_DIGITS  = 2'd1,
        PH_STOPPED = 2'd2
    } phase_t;

    // Header verdict as it stands once the current byte is folded in.
    typedef struct packed {
        logic              all_zero;
        logic              csum_ok;
        logic              is_dir;
        logic              is_hardlink;
        logic [SIZE_W-1:0] size;
    } hdr_verdict_t;

    typedef struct packed {
        phase_t            phase;
        logic [SIZE_W-1:0] value;
    } octal_t;

    // One byte of an octal field: skip leading spaces, stop at a non-digit.
    function automatic octal_t octal_step(octal_t cur, logic [7:0] b);
        octal_t res;
        res = cur;
        if (cur.phase == PH_SKIP && b == CHAR_SPACE) begin
            res = cur;
        end else if ((cur.phase == PH_SKIP || cur.phase == PH_DIGITS)
                     && b >= CHAR_ZERO && b <= CHAR_SEVEN) begin
            res.value = {cur.value[SIZE_W-4:0], b[2:0]};
            res.phase = PH_DIGITS;
        end else begin
            res.phase = PH_STOPPED;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== sv/trsp_header.sv =====
// Header field tracker: checksum sum, octal size and checksum, name end, link flag.
`default_nettype none

module trsp_header (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      step,
    input  wire logic [7:0]                data_byte,
    input  wire logic [trsp_pkg::OFS_W-1:0] offset,
    output trsp_pkg::hdr_verdict_t         verdict
);
    import trsp_pkg::*;

    logic [SUM_W-1:0]  sum_reg, sum_next;
    octal_t            size_reg, size_next;
    octal_t            csum_reg, csum_next;
    logic [7:0]        name_last_reg, name_last_next;
    logic              name_term_reg, name_term_next;
    logic [7:0]        link_reg, link_next;
    logic              zero_reg, zero_next;

    logic              in_csum;
    logic              in_size;
    octal_t            csum_ext;

    assign in_csum = offset >= OFS_CSUM_FIRST && offset <= OFS_CSUM_LAST;
    assign in_size = offset >= OFS_SIZE_FIRST && offset <= OFS_SIZE_LAST;

    always_comb
    begin
        sum_next = sum_reg + (in_csum ? SUM_W'(CHAR_SPACE) : SUM_W'(data_byte));
        zero_next = zero_reg && (data_byte == 8'd0);

        name_last_next = name_last_reg;
        name_term_next = name_term_reg;
        if (offset < OFS_NAME_END && !name_term_reg) begin
            if (data_byte == 8'd0)
                name_term_next = 1'b1;
            else
                name_last_next = data_byte;
        end

        size_next = in_size ? octal_step(size_reg, data_byte) : size_reg;

        // checksum keeps the low bits only; run it through the wide step
        csum_ext = octal_step(csum_reg, data_byte);
        csum_ext.value = {{(SIZE_W-CSUM_W){1'b0}}, csum_ext.value[CSUM_W-1:0]};
        csum_next = in_csum ? csum_ext : csum_reg;

        link_next = (offset == OFS_LINK) ? data_byte : link_reg;
    end

    always_comb
    begin
        verdict.all_zero    = zero_next;
        verdict.csum_ok     = csum_next.value[CSUM_W-1:0] == CSUM_W'(sum_next);
        verdict.is_dir      = name_last_next == CHAR_SLASH;
        verdict.is_hardlink = link_next == CHAR_HARDLINK;
        verdict.size        = size_next.value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sum_reg       <= '0;
            size_reg      <= '{phase: PH_SKIP, value: '0};
            csum_reg      <= '{phase: PH_SKIP, value: '0};
            name_last_reg <= '0;
            name_term_reg <= 1'b0;
            link_reg      <= '0;
            zero_reg      <= 1'b1;
        end else if (step) begin
            if (offset == OFS_LAST) begin
                // clear for the next header
                sum_reg       <= '0;
                size_reg      <= '{phase: PH_SKIP, value: '0};
                csum_reg      <= '{phase: PH_SKIP, value: '0};
                name_last_reg <= '0;
                name_term_reg <= 1'b0;
                link_reg      <= '0;
                zero_reg      <= 1'b1;
            end else begin
                sum_reg       <= sum_next;
                size_reg      <= size_next;
                csum_reg      <= csum_next;
                name_last_reg <= name_last_next;
                name_term_reg <= name_term_next;
                link_reg      <= link_next;
                zero_reg      <= zero_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/tar_record_stream_parser.sv =====
// Top level of the tar record stream parser: mode control and result register.
//
//  channel  signals                                    dir  width
//  input    in_valid, in_ready, data_byte              in   8
//  output   out_valid, out_ready, out_byte, byte_kind, out  8+3+3+36+1
//           header_event, entry_size, last_payload
//
// One item per cycle; a byte's result appears in the cycle after acceptance.
// The rate is set by the single result register: in_ready is high while the
// register is empty or being drained in the same cycle.
// Reset puts the parser at offset 0 of a header record with fields cleared.
// An output stall holds the result register and drops in_ready.
`default_nettype none

module tar_record_stream_parser (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [7:0]                  data_byte,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [7:0]                       out_byte,
    output logic [2:0]                       byte_kind,
    output logic [2:0]                       header_event,
    output logic [trsp_pkg::SIZE_W-1:0]      entry_size,
    output logic                             last_payload
);
    import trsp_pkg::*;

    mode_t              mode_reg, mode_next;
    logic [OFS_W-1:0]   ofs_reg;
    logic [SIZE_W-1:0]  remain_reg, remain_next;
    logic [SIZE_W-1:0]  remain_dec;

    logic               out_valid_reg;
    logic [7:0]         byte_reg;
    kind_t              kind_reg, kind_next;
    event_t             event_reg, event_next;
    logic [SIZE_W-1:0]  size_reg, size_next;
    logic               last_reg, last_next;

    logic               accept;
    logic               rec_end;
    hdr_verdict_t       verdict;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign rec_end  = ofs_reg == OFS_LAST;
    assign remain_dec = remain_reg - SIZE_W'(1);

    trsp_header u_header (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (accept && mode_reg == MODE_HEADER),
        .data_byte (data_byte),
        .offset    (ofs_reg),
        .verdict   (verdict)
    );

    // next mode and payload counter
    always_comb
    begin
        mode_next   = mode_reg;
        remain_next = remain_reg;
        case (mode_reg)
            MODE_HEADER: begin
                if (rec_end) begin
                    if (verdict.all_zero)
                        mode_next = MODE_END;
                    else if (!verdict.csum_ok)
                        mode_next = MODE_ERROR;
                    else if (!verdict.is_dir && !verdict.is_hardlink
                             && verdict.size != '0) begin
                        mode_next   = MODE_PAYLOAD;
                        remain_next = verdict.size;
                    end
                end
            end
            MODE_PAYLOAD: begin
                remain_next = remain_dec;
                if (remain_dec == '0)
                    mode_next = rec_end ? MODE_HEADER : MODE_PADDING;
            end
            MODE_PADDING: begin
                if (rec_end)
                    mode_next = MODE_HEADER;
            end
            MODE_END: mode_next = MODE_END;
            default:  mode_next = MODE_ERROR;
        endcase
    end

    // result fields for the byte at hand
    always_comb
    begin
        kind_next  = KIND_HEADER;
        event_next = EV_NONE;
        size_next  = '0;
        last_next  = 1'b0;
        case (mode_reg)
            MODE_HEADER: begin
                if (rec_end) begin
                    if (verdict.all_zero) begin
                        kind_next  = KIND_END_RECORD;
                        event_next = EV_END;
                    end else if (!verdict.csum_ok) begin
                        event_next = EV_CSUM_ERR;
                    end else if (verdict.is_dir) begin
                        event_next = EV_DIRECTORY;
                    end else if (verdict.is_hardlink) begin
                        event_next = EV_HARDLINK;
                    end else begin
                        event_next = EV_FILE;
                        size_next  = verdict.size;
                    end
                end
            end
            MODE_PAYLOAD: begin
                kind_next = KIND_PAYLOAD;
                last_next = remain_dec == '0;
            end
            MODE_PADDING: kind_next = KIND_PADDING;
            MODE_END:     kind_next = KIND_AFTER_END;
            default:      kind_next = KIND_AFTER_ERROR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg      <= MODE_HEADER;
            ofs_reg       <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                mode_reg   <= mode_next;
                ofs_reg    <= ofs_reg + OFS_W'(1);
                remain_reg <= remain_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            byte_reg  <= data_byte;
            kind_reg  <= kind_next;
            event_reg <= event_next;
            size_reg  <= size_next;
            last_reg  <= last_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = byte_reg;
    assign byte_kind    = kind_reg;
    assign header_event = event_reg;
    assign entry_size   = size_reg;
    assign last_payload = last_reg;

    a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_PAYLOAD |-> remain_reg != '0)
        else $error("payload mode with zero bytes remaining");

    a_end_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_END |=> mode_reg == MODE_END)
        else $error("left end mode");

    a_last_is_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_payload |-> byte_kind == KIND_PAYLOAD)
        else $error("last payload flag on a non-payload item");

    a_event_at_boundary: assert property (@(posedge clk) disable iff (!rst_n)
        accept && mode_reg == MODE_HEADER && !rec_end |=> event_reg == EV_NONE)
        else $error("header event before record end");

    a_size_with_file: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && entry_size != '0 |-> header_event == EV_FILE)
        else $error("entry size without file event");

endmodule

`default_nettype wire
